@@ design/spr_pkg.sv @@
// shared types and constants for the shelf rectangle packer
// no dependencies; every other design file but spr_ram imports this package
package spr_pkg;

  localparam int unsigned COORD_W   = 13;
  localparam int unsigned HANDLE_W  = 8;
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // intermediate width for coordinate sums, also holds COORD_LIMIT
  localparam int unsigned CALC_W = 17;

  localparam int unsigned MAX_HANDLES_DEF = 256;
  localparam int unsigned COORD_LIMIT     = 4096;

  localparam logic [COORD_W-1:0] ATLAS_SIZE_RST   = 13'd4096;
  localparam logic [LIMIT_W-1:0] HANDLE_LIMIT_RST = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_LIMIT = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PACK   = 3'd0,
    FUNC_ROOM   = 3'd1,
    FUNC_FIND   = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef struct packed {
    logic [COORD_W-1:0] left_edge;
    logic [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0] right_edge;
    logic [COORD_W-1:0] bottom_edge;
  } rect_t;

  localparam int unsigned RECT_W = $bits(rect_t);

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [COORD_W-1:0]  rect_width;
    logic [COORD_W-1:0]  rect_height;
    logic [HANDLE_W-1:0] query_handle;
  } req_t;

  // placement outcome, handed from the placer to the handle table
  typedef struct packed {
    logic  placed;
    logic  rejected;
    logic  overflowed;
    logic  room;
    logic  forget;
    rect_t rect;
  } place_res_t;

endpackage

@@ design/spr_ram.sv @@
// generic single-port-write, single-port-read RAM with registered read data
// depends on nothing
module spr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/spr_place.sv @@
// shelf placer: cursor, row height and handle counter, pack and room decisions
// depends on spr_pkg
module spr_place import spr_pkg::*; #(
  parameter int unsigned MAX_HANDLES = MAX_HANDLES_DEF,
  localparam int unsigned HW = $clog2(MAX_HANDLES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  req_t                req_i,
  input  logic [COORD_W-1:0]  atlas_width_i,
  input  logic [COORD_W-1:0]  atlas_height_i,
  input  logic [LIMIT_W-1:0]  handle_limit_i,
  output place_res_t          res_o,
  output logic [HW-1:0]       wr_addr_o,
  output logic [HANDLE_W-1:0] new_handle_o
);

  localparam int unsigned CW = $clog2(MAX_HANDLES + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned NW = (CW > HANDLE_W) ? CW : HANDLE_W;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d, rh_q, rh_d;
  logic [CW-1:0]      nh_q, nh_d, nh2;
  logic [CALC_W-1:0]  aw, ah, w, h, cx, cy, rh;
  logic [CALC_W-1:0]  cx1, cy1, rh1, cx2, cy2, rh2, rh3, right_x, bottom_y;
  logic [LW-1:0]      lim, nh_ext;
  logic [NW-1:0]      hd_ext;
  logic               is_pack, is_room, is_clear;
  logic               reject, wrap, ovf, placed, fits_fresh, fits_row;

  always_comb begin
    is_pack  = 1'b0;
    is_room  = 1'b0;
    is_clear = 1'b0;
    case (req_i.func)
      FUNC_PACK:  is_pack  = req_valid_i;
      FUNC_ROOM:  is_room  = req_valid_i;
      FUNC_CLEAR: is_clear = req_valid_i;
      default:    is_pack  = 1'b0;
    endcase
  end

  always_comb begin
    // atlas sizes above the coordinate limit act as the limit
    aw = CALC_W'(atlas_width_i);
    if (aw > CALC_W'(COORD_LIMIT)) aw = CALC_W'(COORD_LIMIT);
    ah = CALC_W'(atlas_height_i);
    if (ah > CALC_W'(COORD_LIMIT)) ah = CALC_W'(COORD_LIMIT);

    if (handle_limit_i == '0) begin
      lim = LW'(1);
    end else if (LW'(handle_limit_i) > LW'(MAX_HANDLES)) begin
      lim = LW'(MAX_HANDLES);
    end else begin
      lim = LW'(handle_limit_i);
    end

    w  = CALC_W'(req_i.rect_width);
    h  = CALC_W'(req_i.rect_height);
    cx = CALC_W'(cx_q);
    cy = CALC_W'(cy_q);
    rh = CALC_W'(rh_q);

    reject = (w > aw) || (h > ah);

    // open a new row when the rest of this one is too narrow
    wrap = (cx + w) > aw;
    cy1  = wrap ? cy + rh : cy;
    cx1  = wrap ? '0 : cx;
    rh1  = wrap ? '0 : rh;

    nh_ext = LW'(nh_q);
    ovf    = ((cy1 + h) > ah) || (nh_ext >= lim);
    cx2    = ovf ? '0 : cx1;
    cy2    = ovf ? '0 : cy1;
    rh2    = ovf ? '0 : rh1;
    nh2    = ovf ? '0 : nh_q;
    rh3    = (h > rh2) ? h : rh2;

    right_x  = cx2 + w;
    bottom_y = cy2 + h;
    placed   = is_pack && !reject;

    fits_fresh = (aw >= w) && ((cy + rh + h) <= ah);
    fits_row   = ((cx + w) <= aw) && ((cy + h) <= ah);

    cx_d = cx_q;
    cy_d = cy_q;
    rh_d = rh_q;
    nh_d = nh_q;
    if (is_clear) begin
      cx_d = '0;
      cy_d = '0;
      rh_d = '0;
      nh_d = '0;
    end
    if (placed) begin
      cx_d = COORD_W'(right_x);
      cy_d = COORD_W'(cy2);
      rh_d = COORD_W'(rh3);
      nh_d = nh2 + 1'b1;
    end

    res_o.placed     = placed;
    res_o.rejected   = is_pack && reject;
    res_o.overflowed = placed && ovf;
    res_o.room       = is_room && (fits_fresh || fits_row);
    res_o.forget     = is_clear || (placed && ovf);
    res_o.rect.left_edge   = COORD_W'(cx2);
    res_o.rect.top_edge    = COORD_W'(cy2);
    res_o.rect.right_edge  = COORD_W'(right_x);
    res_o.rect.bottom_edge = COORD_W'(bottom_y);

    hd_ext       = NW'(nh2);
    new_handle_o = hd_ext[HANDLE_W-1:0];
    wr_addr_o    = HW'(nh2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      rh_q <= '0;
      nh_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      rh_q <= rh_d;
      nh_q <= nh_d;
    end
  end

endmodule

@@ design/spr_table.sv @@
// handle table: valid bits in flops, rectangles in a RAM with write forwarding
// depends on spr_pkg and spr_ram
module spr_table import spr_pkg::*; #(
  parameter int unsigned MAX_HANDLES = MAX_HANDLES_DEF,
  localparam int unsigned HW = $clog2(MAX_HANDLES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [HANDLE_W-1:0] rd_handle_i,
  input  logic                req_valid_i,
  input  req_t                req_i,
  input  place_res_t          place_i,
  input  logic [HW-1:0]       wr_addr_i,
  output logic                found_o,
  output rect_t               rect_o
);

  localparam int unsigned QW = (HW > HANDLE_W) ? HW : HANDLE_W;

  logic [MAX_HANDLES-1:0] valid_q, valid_d;
  logic [QW-1:0]          rd_ext, q_ext;
  logic [HW-1:0]          rd_addr, q_idx;
  logic                   in_table, is_find, is_remove;
  logic [RECT_W-1:0]      rdata;
  logic                   byp_q;
  rect_t                  byp_rect_q;

  // read is issued with the handle on the port, data lines up with the request
  assign rd_ext  = QW'(rd_handle_i);
  assign rd_addr = rd_ext[HW-1:0];

  assign q_ext    = QW'(req_i.query_handle);
  assign q_idx    = q_ext[HW-1:0];
  assign in_table = {1'b0, q_ext} < (QW + 1)'(MAX_HANDLES);

  always_comb begin
    is_find   = 1'b0;
    is_remove = 1'b0;
    case (req_i.func)
      FUNC_FIND:   is_find   = req_valid_i;
      FUNC_REMOVE: is_remove = req_valid_i;
      default:     is_find   = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (place_i.forget) valid_d = '0;
    if (place_i.placed) valid_d[wr_addr_i] = 1'b1;
    if (is_remove && in_table) valid_d[q_idx] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      byp_q   <= place_i.placed && (wr_addr_i == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_rect_q <= place_i.rect;
  end

  spr_ram #(
    .WIDTH (RECT_W),
    .DEPTH (MAX_HANDLES)
  ) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (place_i.placed),
    .waddr_i (wr_addr_i),
    .wdata_i (place_i.rect),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign found_o = is_find && in_table && valid_q[q_idx];
  assign rect_o  = byp_q ? byp_rect_q : rect_t'(rdata);

endmodule

@@ design/shelf_rectangle_packer_unit.sv @@
// top level of the shelf rectangle packer: config registers, request and result registers
// depends on spr_pkg, spr_place, spr_table

// Takes one request per clock: busy is always low and start is accepted in every
// cycle. Each request gives exactly one result, shown on the result ports with
// done_o high for a single cycle: in the cycle after the transfer the request
// register and the handle RAM read data are ready together, and the placement
// logic feeds the result register at the end of that cycle. The receiver cannot
// stall, so the result must be captured in the cycle done_o is high. Rectangles
// live in a RAM of MAX_HANDLES entries; their valid bits are flops cleared by
// reset, so no clearing pass is needed. Configuration may be written only while
// no request is in flight.
module shelf_rectangle_packer_unit import spr_pkg::*; #(
  parameter int unsigned MAX_HANDLES = MAX_HANDLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [COORD_W-1:0]   rect_width_i,
  input  logic [COORD_W-1:0]   rect_height_i,
  input  logic [HANDLE_W-1:0]  query_handle_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  output logic                 done_o,
  output logic [HANDLE_W-1:0]  new_handle_o,
  output logic                 status_o,
  output logic                 overflowed_o,
  output logic                 room_o,
  output logic                 found_o,
  output logic [COORD_W-1:0]   left_edge_o,
  output logic [COORD_W-1:0]   top_edge_o,
  output logic [COORD_W-1:0]   right_edge_o,
  output logic [COORD_W-1:0]   bottom_edge_o
);

  localparam int unsigned HW = $clog2(MAX_HANDLES);

  logic [COORD_W-1:0]  atlas_width_q, atlas_height_q;
  logic [LIMIT_W-1:0]  handle_limit_q;
  logic                accept;
  logic                req_valid_q;
  req_t                req_q;
  place_res_t          place_res;
  logic [HW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] new_handle;
  logic                tbl_found;
  rect_t               tbl_rect;

  logic                done_q;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                status_q, overflowed_q, room_q, found_q;
  rect_t               rect_q, rect_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q  <= ATLAS_SIZE_RST;
      atlas_height_q <= ATLAS_SIZE_RST;
      handle_limit_q <= HANDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_wdata_i;
        CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_wdata_i;
        CFG_HANDLE_LIMIT: handle_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default:          atlas_width_q  <= atlas_width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= accept;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.func         <= func_i;
      req_q.rect_width   <= rect_width_i;
      req_q.rect_height  <= rect_height_i;
      req_q.query_handle <= query_handle_i;
    end
  end

  spr_place #(
    .MAX_HANDLES (MAX_HANDLES)
  ) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_q),
    .req_i          (req_q),
    .atlas_width_i  (atlas_width_q),
    .atlas_height_i (atlas_height_q),
    .handle_limit_i (handle_limit_q),
    .res_o          (place_res),
    .wr_addr_o      (wr_addr),
    .new_handle_o   (new_handle)
  );

  spr_table #(
    .MAX_HANDLES (MAX_HANDLES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_handle_i (query_handle_i),
    .req_valid_i (req_valid_q),
    .req_i       (req_q),
    .place_i     (place_res),
    .wr_addr_i   (wr_addr),
    .found_o     (tbl_found),
    .rect_o      (tbl_rect)
  );

  // fields a request does not produce read as zero
  always_comb begin
    handle_d = place_res.placed ? new_handle : '0;
    if (place_res.placed) begin
      rect_d = place_res.rect;
    end else if (tbl_found) begin
      rect_d = tbl_rect;
    end else begin
      rect_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      handle_q     <= handle_d;
      status_q     <= place_res.rejected;
      overflowed_q <= place_res.overflowed;
      room_q       <= place_res.room;
      found_q      <= tbl_found;
      rect_q       <= rect_d;
    end
  end

  assign done_o        = done_q;
  assign new_handle_o  = handle_q;
  assign status_o      = status_q;
  assign overflowed_o  = overflowed_q;
  assign room_o        = room_q;
  assign found_o       = found_q;
  assign left_edge_o   = rect_q.left_edge;
  assign top_edge_o    = rect_q.top_edge;
  assign right_edge_o  = rect_q.right_edge;
  assign bottom_edge_o = rect_q.bottom_edge;

endmodule

@@ design/spr_checker.sv @@
// port-level checks for the shelf rectangle packer, bound to the top level
// depends on spr_pkg and shelf_rectangle_packer_unit
module spr_checker import spr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [HANDLE_W-1:0] new_handle_o,
  input logic                status_o,
  input logic                overflowed_o,
  input logic                room_o,
  input logic                found_o,
  input logic [COORD_W-1:0]  left_edge_o,
  input logic [COORD_W-1:0]  top_edge_o,
  input logic [COORD_W-1:0]  right_edge_o,
  input logic [COORD_W-1:0]  bottom_edge_o
);

  // one result per accepted transfer
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == ($past(start && !busy && rst_ni, 2) && $past(rst_ni, 1)))
    else $error("result strobe does not match accepted transfers");

  a_exclusive_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({status_o, overflowed_o, room_o, found_o}))
    else $error("more than one answer flag set in a result");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (new_handle_o == '0 && left_edge_o == '0 &&
      top_edge_o == '0 && right_edge_o == '0 && bottom_edge_o == '0))
    else $error("rejected pack carries a rectangle or handle");

  a_edges_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (right_edge_o >= left_edge_o && bottom_edge_o >= top_edge_o))
    else $error("rectangle edges out of order");

  // after a forced reset the first handle is handed out again
  a_overflow_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflowed_o) |-> (new_handle_o == '0 && left_edge_o == '0 &&
      top_edge_o == '0))
    else $error("overflowed pack not placed at origin with handle zero");

endmodule

bind shelf_rectangle_packer_unit spr_checker u_spr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .new_handle_o  (new_handle_o),
  .status_o      (status_o),
  .overflowed_o  (overflowed_o),
  .room_o        (room_o),
  .found_o       (found_o),
  .left_edge_o   (left_edge_o),
  .top_edge_o    (top_edge_o),
  .right_edge_o  (right_edge_o),
  .bottom_edge_o (bottom_edge_o)
);
